>>> hw/rtl/otwo_pkg.sv
// Shared types, constants and the arctangent table of the three-wheel omni odometry block.
package otwo_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
   localparam int ATAN_IDX_W   = 5;

   localparam int SPEED_W     = 24;
   localparam int TIME_W      = 16;
   localparam int POS_W       = 32;
   localparam int HEAD_W      = 16;
   localparam int CSR_W       = 23;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SNAP_TOL   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_RADIUS = CSR_INDEX_W'(1);

   localparam logic [CSR_W-1:0] SNAP_TOL_RESET   = CSR_W'(66);
   localparam logic [CSR_W-1:0] INV_RADIUS_RESET = CSR_W'(78019);

   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
   localparam logic [31:0] INV_SQRT3_Q30   = 32'd619925131;
   localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
   localparam logic [31:0] DIV3_RECIP      = 32'd89478486;
   localparam int          DIV3_SHIFT      = 28;

   typedef struct packed {
      logic signed [SPEED_W-1:0] meas_speed_a;
      logic signed [SPEED_W-1:0] meas_speed_b;
      logic signed [SPEED_W-1:0] meas_speed_c;
      logic signed [SPEED_W-1:0] cmd_speed_a;
      logic signed [SPEED_W-1:0] cmd_speed_b;
      logic signed [SPEED_W-1:0] cmd_speed_c;
      logic        [TIME_W-1:0]  step_time;
   } otwo_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic        [HEAD_W-1:0]  heading_out;
      logic signed [SPEED_W-1:0] vel_x;
      logic signed [SPEED_W-1:0] vel_y;
      logic signed [SPEED_W-1:0] yaw_rate;
   } otwo_rsp_type;

   function automatic logic [29:0] turn_atan(input logic [ATAN_IDX_W-1:0] idx);
      case (idx)
         5'd0:    turn_atan = 30'd536870912;
         5'd1:    turn_atan = 30'd316933406;
         5'd2:    turn_atan = 30'd167458907;
         5'd3:    turn_atan = 30'd85004756;
         5'd4:    turn_atan = 30'd42667331;
         5'd5:    turn_atan = 30'd21354465;
         5'd6:    turn_atan = 30'd10679838;
         5'd7:    turn_atan = 30'd5340245;
         5'd8:    turn_atan = 30'd2670163;
         5'd9:    turn_atan = 30'd1335087;
         5'd10:   turn_atan = 30'd667544;
         5'd11:   turn_atan = 30'd333772;
         5'd12:   turn_atan = 30'd166886;
         5'd13:   turn_atan = 30'd83443;
         5'd14:   turn_atan = 30'd41722;
         5'd15:   turn_atan = 30'd20861;
         5'd16:   turn_atan = 30'd10430;
         5'd17:   turn_atan = 30'd5215;
         5'd18:   turn_atan = 30'd2608;
         5'd19:   turn_atan = 30'd1304;
         5'd20:   turn_atan = 30'd652;
         5'd21:   turn_atan = 30'd326;
         5'd22:   turn_atan = 30'd163;
         5'd23:   turn_atan = 30'd81;
         default: turn_atan = 30'd0;
      endcase
   endfunction

endpackage

>>> hw/rtl/omni_three_wheel_odometry.sv
// Top level of the three-wheel omni odometry block: sequencer, CORDIC and shared multiplier.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid, req_stall  | req_data  (otwo_req_type)
//  rsp     | out       | rsp_valid, rsp_stall  | rsp_data  (otwo_rsp_type)
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
// A transaction runs from acceptance until the block is ready again through CORDIC_STEPS
// rotation steps, then eleven products through the one shared multiplier, each in a multiply
// state and a consume state, then an output step that loads the result register.
// Reset clears the position, the heading and the result valid flag and restores the CSRs.
// A stalled result holds in its register; the next transaction is accepted meanwhile and
// completes only once that register is free.
module omni_three_wheel_odometry (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  otwo_pkg::otwo_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output otwo_pkg::otwo_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [otwo_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [otwo_pkg::CSR_W-1:0]         csr_wdata
);
   import otwo_pkg::*;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CORD_W = 33;
   localparam int NUM_W  = SPEED_W + 3;
   localparam int MIX_W  = SPEED_W + 2;
   localparam int QUO_W  = SPEED_W + 1;
   localparam int RAD_W  = 32;

   localparam logic signed [PROD_W-1:0] SPD_HI =
      {{(PROD_W-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SPD_LO =
      {{(PROD_W-SPEED_W+1){1'b1}}, {(SPEED_W-1){1'b0}}};
   localparam logic signed [POS_W+1:0] POS_HI = {3'b000, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W+1:0] POS_LO = {3'b111, {(POS_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_MUL,
      ST_CONSUME,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_P,
      OP_Q,
      OP_W,
      OP_CQ,
      OP_SP,
      OP_CP,
      OP_SQ,
      OP_DX,
      OP_DY,
      OP_R,
      OP_DH
   } op_type;

   function automatic logic signed [PROD_W-1:0] rnd_shr(
      input logic signed [PROD_W-1:0] v,
      input int unsigned              n
   );
      logic signed [PROD_W-1:0] half;
      half    = PROD_W'(1) << (n - 1);
      rnd_shr = (v + half) >>> n;
   endfunction

   function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [PROD_W-1:0] v);
      if (v > SPD_HI) begin
         sat_speed = SPD_HI[SPEED_W-1:0];
      end else if (v < SPD_LO) begin
         sat_speed = SPD_LO[SPEED_W-1:0];
      end else begin
         sat_speed = v[SPEED_W-1:0];
      end
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
      if (v > POS_HI) begin
         sat_pos = POS_HI[POS_W-1:0];
      end else if (v < POS_LO) begin
         sat_pos = POS_LO[POS_W-1:0];
      end else begin
         sat_pos = v[POS_W-1:0];
      end
   endfunction

   function automatic logic signed [SPEED_W-1:0] snap(
      input logic signed [SPEED_W-1:0] meas,
      input logic signed [SPEED_W-1:0] cmd,
      input logic        [CSR_W-1:0]   tol
   );
      logic signed [SPEED_W:0] d;
      logic        [SPEED_W:0] mag;
      d    = (SPEED_W+1)'(meas) - (SPEED_W+1)'(cmd);
      mag  = d[SPEED_W] ? (SPEED_W+1)'(-d) : (SPEED_W+1)'(d);
      snap = (mag <= (SPEED_W+1)'(tol)) ? cmd : meas;
   endfunction

   state_type                   state_ff, state_in;
   op_type                      op_ff, op_in;
   logic [CORDIC_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]     acc_x_ff, acc_x_in;
   logic signed [POS_W-1:0]     acc_y_ff, acc_y_in;
   logic [ANGLE_BITS-1:0]       acc_heading_ff, acc_heading_in;
   logic [CSR_W-1:0]            tol_ff, tol_in;
   logic [CSR_W-1:0]            inv_radius_ff, inv_radius_in;

   logic signed [SPEED_W-1:0]   v1_ff, v2_ff, v3_ff;
   logic [TIME_W-1:0]           dt_ff;
   logic signed [CORD_W-1:0]    x_ff, y_ff, z_ff;
   logic                        flip_ff;
   logic signed [PROD_W-1:0]    prod_ff, acc_ff;
   logic signed [MIX_W-1:0]     p_ff, q_ff;
   logic signed [SPEED_W-1:0]   w_ff, vx_ff, vy_ff;
   logic signed [RAD_W-1:0]     r_ff;
   otwo_rsp_type                rsp_data_ff;

   logic                        req_take;
   logic                        rsp_load;
   logic signed [NUM_W-1:0]     num_w;
   logic                        num_neg;
   logic [NUM_W-1:0]            num_mag1;
   logic signed [MIX_W-1:0]     diff_w, sum3_w;
   logic signed [CORD_W-1:0]    cos_w, sin_w;
   logic signed [CORD_W-1:0]    x_sh, y_sh, atan_w;
   logic [31:0]                 z_init32;
   logic                        flip_init;
   logic signed [CORD_W-1:0]    z_init;
   logic signed [MUL_W-1:0]     mul_a, mul_b;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PROD_W-1:0]    step_w, dlt_w;
   logic [QUO_W-1:0]            quo_w;
   logic [HEAD_W-1:0]           heading_w;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign num_w    = (NUM_W'(v1_ff) <<< 1) - NUM_W'(v2_ff) - NUM_W'(v3_ff);
   assign num_neg  = num_w[NUM_W-1];
   assign num_mag1 = (num_neg ? NUM_W'(-num_w) : NUM_W'(num_w)) + NUM_W'(1);
   assign diff_w   = MIX_W'(v3_ff) - MIX_W'(v2_ff);
   assign sum3_w   = MIX_W'(v1_ff) + MIX_W'(v2_ff) + MIX_W'(v3_ff);

   assign cos_w = flip_ff ? -x_ff : x_ff;
   assign sin_w = flip_ff ? -y_ff : y_ff;

   assign x_sh   = x_ff >>> cnt_ff;
   assign y_sh   = y_ff >>> cnt_ff;
   assign atan_w = $signed(CORD_W'(turn_atan(ATAN_IDX_W'(cnt_ff))));

   assign z_init32  = 32'(acc_heading_ff) << (32 - ANGLE_BITS);
   assign flip_init = z_init32[31] ^ z_init32[30];
   assign z_init    = CORD_W'($signed({z_init32[31] ^ flip_init, z_init32[30:0]}));

   assign heading_w = HEAD_W'((48'(acc_heading_ff) << HEAD_W) >> ANGLE_BITS);

   always_comb begin
      case (op_ff)
         OP_P: begin
            mul_a = $signed(MUL_W'(num_mag1));
            mul_b = $signed(MUL_W'(DIV3_RECIP));
         end
         OP_Q: begin
            mul_a = MUL_W'(diff_w);
            mul_b = $signed(MUL_W'(INV_SQRT3_Q30));
         end
         OP_W: begin
            mul_a = MUL_W'(sum3_w);
            mul_b = $signed(MUL_W'(inv_radius_ff));
         end
         OP_CQ: begin
            mul_a = MUL_W'(cos_w);
            mul_b = MUL_W'(q_ff);
         end
         OP_SP: begin
            mul_a = MUL_W'(sin_w);
            mul_b = MUL_W'(p_ff);
         end
         OP_CP: begin
            mul_a = MUL_W'(cos_w);
            mul_b = MUL_W'(p_ff);
         end
         OP_SQ: begin
            mul_a = MUL_W'(sin_w);
            mul_b = MUL_W'(q_ff);
         end
         OP_DX: begin
            mul_a = MUL_W'(vx_ff);
            mul_b = $signed(MUL_W'(dt_ff));
         end
         OP_DY: begin
            mul_a = MUL_W'(vy_ff);
            mul_b = $signed(MUL_W'(dt_ff));
         end
         OP_R: begin
            mul_a = MUL_W'(w_ff);
            mul_b = $signed(MUL_W'(dt_ff));
         end
         OP_DH: begin
            mul_a = MUL_W'(r_ff);
            mul_b = $signed(MUL_W'(INV_TWO_PI_Q32));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign step_w  = rnd_shr(prod_ff, 16);
   assign dlt_w   = rnd_shr(prod_ff, 56 - ANGLE_BITS);
   assign quo_w   = prod_ff[DIV3_SHIFT +: QUO_W];

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      acc_x_in       = acc_x_ff;
      acc_y_in       = acc_y_ff;
      acc_heading_in = acc_heading_ff;
      tol_in         = tol_ff;
      inv_radius_in  = inv_radius_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_SNAP_TOL:   tol_in        = csr_wdata;
            CSR_INV_RADIUS: inv_radius_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ROTATE;
               cnt_in   = '0;
            end
         end
         ST_ROTATE: begin
            cnt_in = cnt_ff + CORDIC_CNT_W'(1);
            if (cnt_ff == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_MUL;
               op_in    = OP_P;
            end
         end
         ST_MUL: begin
            state_in = ST_CONSUME;
         end
         ST_CONSUME: begin
            case (op_ff)
               OP_DX: acc_x_in = sat_pos((POS_W+2)'(acc_x_ff) + (POS_W+2)'(step_w));
               OP_DY: acc_y_in = sat_pos((POS_W+2)'(acc_y_ff) + (POS_W+2)'(step_w));
               OP_DH: acc_heading_in = acc_heading_ff + dlt_w[ANGLE_BITS-1:0];
               default: ;
            endcase
            if (op_ff == OP_DH) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL;
               op_in    = op_type'(op_ff + 4'd1);
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         op_ff          <= OP_P;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         acc_x_ff       <= '0;
         acc_y_ff       <= '0;
         acc_heading_ff <= '0;
         tol_ff         <= SNAP_TOL_RESET;
         inv_radius_ff  <= INV_RADIUS_RESET;
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         acc_x_ff       <= acc_x_in;
         acc_y_ff       <= acc_y_in;
         acc_heading_ff <= acc_heading_in;
         tol_ff         <= tol_in;
         inv_radius_ff  <= inv_radius_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         v1_ff   <= snap(req_data.meas_speed_a, req_data.cmd_speed_a, tol_ff);
         v2_ff   <= snap(req_data.meas_speed_b, req_data.cmd_speed_b, tol_ff);
         v3_ff   <= snap(req_data.meas_speed_c, req_data.cmd_speed_c, tol_ff);
         dt_ff   <= req_data.step_time;
         x_ff    <= $signed(CORD_W'(CORDIC_GAIN_Q30));
         y_ff    <= '0;
         z_ff    <= z_init;
         flip_ff <= flip_init;
      end

      if (state_ff == ST_ROTATE) begin
         if (!z_ff[CORD_W-1]) begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - atan_w;
         end else begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + atan_w;
         end
      end

      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end

      if (state_ff == ST_CONSUME) begin
         case (op_ff)
            OP_P:  p_ff  <= num_neg ? -$signed(MIX_W'(quo_w)) : $signed(MIX_W'(quo_w));
            OP_Q:  q_ff  <= MIX_W'(rnd_shr(prod_ff, 30));
            OP_W:  w_ff  <= sat_speed(rnd_shr(prod_ff, 16));
            OP_CQ: acc_ff <= prod_ff;
            OP_SP: vx_ff <= sat_speed(rnd_shr(acc_ff - prod_ff, 30));
            OP_CP: acc_ff <= prod_ff;
            OP_SQ: vy_ff <= sat_speed(rnd_shr(acc_ff + prod_ff, 30));
            OP_R:  r_ff  <= RAD_W'(rnd_shr(prod_ff, 8));
            default: ;
         endcase
      end

      if (rsp_load) begin
         rsp_data_ff.pos_x       <= acc_x_ff;
         rsp_data_ff.pos_y       <= acc_y_ff;
         rsp_data_ff.heading_out <= heading_w;
         rsp_data_ff.vel_x       <= vx_ff;
         rsp_data_ff.vel_y       <= vy_ff;
         rsp_data_ff.yaw_rate    <= w_ff;
      end
   end

   a_take_starts_rotation: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_ROTATE)
      else $error("An accepted transaction did not start the rotation.");

   a_result_from_out_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("A result appeared outside the output step.");

   a_out_waits_for_free_register: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_valid_ff && rsp_stall |=> state_ff == ST_OUT)
      else $error("A result overwrote a stalled transaction.");

   a_heading_update_point: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(acc_heading_ff) |->
         $past(state_ff == ST_CONSUME && op_ff == OP_DH))
      else $error("The heading changed outside its update step.");

   a_position_update_point: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(acc_x_ff) |->
         $past(state_ff == ST_CONSUME && op_ff == OP_DX))
      else $error("The x position changed outside its update step.");

endmodule

>>> verif/omni_three_wheel_odometry_tb.sv
// Self-checking testbench of the three-wheel omni odometry block with its own fixed-point predictor.
module omni_three_wheel_odometry_tb;
   import otwo_pkg::*;

   localparam int     ANG             = ANGLE_BITS;
   localparam int     ROT_STEPS       = CORDIC_STEPS;
   localparam longint SPD_MIN         = -64'sd8388608;
   localparam longint SPD_MAX         = 64'sd8388607;
   localparam longint POS_MIN         = -64'sd2147483648;
   localparam longint POS_MAX         = 64'sd2147483647;
   localparam longint ROT_GAIN        = 64'sd652032874;
   localparam longint RECIP_SQRT3     = 64'sd619925131;
   localparam longint RECIP_TWO_PI    = 64'sd683565276;
   localparam int     WATCHDOG_LIMIT  = 4000;
   localparam int     SETTLE_CYCLES   = 60;
   localparam logic [23:0] S_MAX      = 24'h7FFFFF;
   localparam logic [23:0] S_MIN      = 24'h800000;
   localparam logic [CSR_W-1:0] REG_MAX = '1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   otwo_req_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   otwo_rsp_type           rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]       csr_wdata = '0;

   longint snap_band   = 66;
   longint inv_radius  = 78019;
   longint odo_x       = 0;
   longint odo_y       = 0;
   longint odo_heading = 0;
   longint atan_turn [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   otwo_rsp_type expected_poses [$];
   int           errors      = 0;
   int           idle_cycles = 0;
   int           burst_left  = 0;
   int           stall_run   = 0;

   omni_three_wheel_odometry u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic longint round_shift(input longint v, input int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint snapped(input longint meas, input longint cmd);
      longint d;
      d = meas - cmd;
      if (d < 0) begin
         d = -d;
      end
      return (d <= snap_band) ? cmd : meas;
   endfunction

   function automatic void heading_sincos(input longint angle, output longint cs,
                                          output longint sn);
      logic [31:0] z32;
      longint      z, x, y, nx;
      bit          flip;
      z32 = 32'(angle << (32 - ANG));
      flip = 1'b0;
      if (z32 >= 32'h4000_0000 && z32 < 32'hC000_0000) begin
         z32 = z32 + 32'h8000_0000;
         flip = 1'b1;
      end
      z = longint'($signed(z32));
      x = ROT_GAIN;
      y = 0;
      for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_turn[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_turn[i];
         end
         x = nx;
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   function automatic void advance_odometry(input otwo_req_type t, output otwo_rsp_type res);
      longint v1, v2, v3, dt, tri_sum, p, q, cs, sn, vx, vy, w, r, delta, hout;
      v1 = snapped($signed(t.meas_speed_a), $signed(t.cmd_speed_a));
      v2 = snapped($signed(t.meas_speed_b), $signed(t.cmd_speed_b));
      v3 = snapped($signed(t.meas_speed_c), $signed(t.cmd_speed_c));
      dt = longint'(t.step_time);
      tri_sum = 2 * v1 - v2 - v3;
      p = (tri_sum >= 0) ? (tri_sum + 1) / 3 : -((1 - tri_sum) / 3);
      q = round_shift((v3 - v2) * RECIP_SQRT3, 30);
      heading_sincos(odo_heading, cs, sn);
      vx = clamp(round_shift(cs * q - sn * p, 30), SPD_MIN, SPD_MAX);
      vy = clamp(round_shift(cs * p + sn * q, 30), SPD_MIN, SPD_MAX);
      w = clamp(round_shift((v1 + v2 + v3) * inv_radius, 16), SPD_MIN, SPD_MAX);
      odo_x = clamp(odo_x + round_shift(vx * dt, 16), POS_MIN, POS_MAX);
      odo_y = clamp(odo_y + round_shift(vy * dt, 16), POS_MIN, POS_MAX);
      r = round_shift(w * dt, 8);
      delta = round_shift(r * RECIP_TWO_PI, 56 - ANG);
      odo_heading = (odo_heading + delta) & ((longint'(1) << ANG) - 1);
      if (ANG >= 16) begin
         hout = odo_heading >> (ANG - 16);
      end else begin
         hout = odo_heading << (16 - ANG);
      end
      res.pos_x = 32'(odo_x);
      res.pos_y = 32'(odo_y);
      res.heading_out = 16'(hout);
      res.vel_x = 24'(vx);
      res.vel_y = 24'(vy);
      res.yaw_rate = 24'(w);
   endfunction

   function automatic otwo_req_type tick(input logic [23:0] ma, mb, mc, ca, cb, cc,
                                         input logic [15:0] dt);
      otwo_req_type t;
      t.meas_speed_a = ma;
      t.meas_speed_b = mb;
      t.meas_speed_c = mc;
      t.cmd_speed_a = ca;
      t.cmd_speed_b = cb;
      t.cmd_speed_c = cc;
      t.step_time = dt;
      return t;
   endfunction

   function automatic logic [23:0] extreme_speed();
      case ($urandom_range(0, 4))
         0: return S_MAX;
         1: return S_MIN;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return 24'h000001;
      endcase
   endfunction

   function automatic void random_wheel(output logic [23:0] meas, output logic [23:0] cmd);
      int     pick;
      longint span, m;
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
         meas = 24'($urandom);
         cmd = 24'($urandom);
      end else if (pick < 14) begin
         cmd = 24'($urandom);
         span = snap_band + 3;
         m = longint'($signed(cmd)) + longint'($urandom_range(0, 32'(2 * span))) - span;
         meas = 24'(clamp(m, SPD_MIN, SPD_MAX));
      end else if (pick < 18) begin
         meas = 24'(longint'($urandom_range(0, 131071)) - 65536);
         cmd = 24'(longint'($urandom_range(0, 131071)) - 65536);
      end else begin
         meas = extreme_speed();
         cmd = extreme_speed();
      end
   endfunction

   function automatic otwo_req_type random_tick();
      logic [23:0] m [3];
      logic [23:0] c [3];
      logic [15:0] dt;
      for (int k = 0; k < 3; k++) begin
         random_wheel(m[k], c[k]);
      end
      case ($urandom_range(0, 9))
         0: dt = 16'h0000;
         1: dt = 16'hFFFF;
         2, 3: dt = 16'($urandom_range(1, 255));
         default: dt = 16'($urandom);
      endcase
      return tick(m[0], m[1], m[2], c[0], c[1], c[2], dt);
   endfunction

   // Wheels a against b and c at near full speed, so the base drives straight.
   function automatic otwo_req_type push_tick(input bit forward);
      longint ma, mb, mc;
      ma = $urandom_range(7000000, 8388607);
      mb = $urandom_range(7000000, 8388607);
      mc = $urandom_range(7000000, 8388607);
      if (!forward) begin
         ma = -ma;
      end else begin
         mb = -mb;
         mc = -mc;
      end
      return tick(24'(ma), 24'(mb), 24'(mc), 24'($urandom), 24'($urandom), 24'($urandom),
                  16'($urandom_range(58000, 65535)));
   endfunction

   task automatic send_tick(input otwo_req_type item);
      otwo_rsp_type want;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_odometry(item, want);
      expected_poses.push_back(want);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_SNAP_TOL) begin
         snap_band = longint'(value);
      end else if (idx == CSR_INV_RADIUS) begin
         inv_radius = longint'(value);
      end
   endtask

   task automatic set_regs(input logic [CSR_W-1:0] tol, input logic [CSR_W-1:0] inv);
      drain();
      write_reg(CSR_SNAP_TOL, tol);
      write_reg(CSR_INV_RADIUS, inv);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 10) begin
            $display("mismatch on %s: expected %h, got %h", name, want, got);
         end
      end
   endtask

   task automatic test_directed();
      write_reg(CSR_INDEX_W'(2), REG_MAX);
      write_reg(CSR_INDEX_W'(3), CSR_W'($urandom));
      send_tick(tick(0, 0, 0, 0, 0, 0, 16'h0000));
      send_tick(tick(0, 0, 0, 0, 0, 0, 16'hFFFF));
      send_tick(tick(S_MAX, S_MAX, S_MAX, 0, 0, 0, 16'hFFFF));
      send_tick(tick(S_MIN, S_MIN, S_MIN, 0, 0, 0, 16'hFFFF));
      send_tick(tick(S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, 16'hFFFF));
      send_tick(tick(S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, 16'hFFFF));
      send_tick(tick(0, S_MIN, S_MAX, 0, 0, 0, 16'h8000));
      send_tick(tick(24'h010042, 24'h00FFBE, 24'h010043, 24'h010000, 24'h010000, 24'h010000,
                     16'd4000));
      send_tick(tick(24'h00FFBD, 24'h010000, 24'h010041, 24'h010000, 24'h010000, 24'h010000,
                     16'd4000));
      send_tick(tick(S_MAX, S_MIN, 24'h000001, 24'h7FFFBD, 24'h800042, 24'h000000, 16'h0001));
      send_tick(tick(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 16'h0001));
      send_tick(tick(24'h000001, 24'hFFFFFF, 24'h000001, S_MIN, S_MAX, S_MIN, 16'h0001));
      send_tick(tick(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 24'hAAAAAA, 24'h555555, 24'hF0F0F0,
                     16'h5555));
      send_tick(tick(24'hAAAAAA, 24'h555555, 24'hF0F0F0, 24'h555555, 24'hAAAAAA, 24'h0F0F0F,
                     16'hAAAA));
      for (int k = 0; k < 4; k++) begin
         send_tick(tick(24'h300000, 24'hD00000, 24'h100000, 0, 0, 0, 16'd20000));
         send_tick(tick(S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, 16'hFFFF));
      end
   endtask

   task automatic test_register_extremes();
      set_regs('0, CSR_W'(1));
      send_tick(tick(24'h123456, 24'h123457, 24'h123455, 24'h123456, 24'h123456, 24'h123456,
                     16'd40000));
      repeat (30) send_tick(random_tick());
      set_regs(REG_MAX, REG_MAX);
      send_tick(tick(S_MAX, S_MAX, S_MIN, 24'h000000, 24'hFFFFFF, S_MAX, 16'hFFFF));
      send_tick(tick(S_MIN, S_MIN, S_MAX, 24'hFFFFFF, 24'h000000, S_MIN, 16'hFFFF));
      repeat (30) send_tick(random_tick());
   endtask

   // With the yaw gain at zero the heading holds, so both directions reach saturation.
   task automatic test_position_saturation();
      int sent;
      set_regs(CSR_W'($urandom_range(0, 4095)), '0);
      for (int dir = 1; dir >= 0; dir--) begin
         sent = 0;
         while (sent < 900 && (dir == 1 ? (odo_x != POS_MAX && odo_y != POS_MAX)
                                        : (odo_x != POS_MIN && odo_y != POS_MIN))) begin
            send_tick(($urandom_range(0, 19) == 0) ? random_tick() : push_tick(dir == 1));
            sent++;
         end
         repeat (8) send_tick(push_tick(dir == 1));
      end
   endtask

   task automatic test_random_mix();
      logic [CSR_W-1:0] tol, inv;
      for (int ph = 0; ph < 4; ph++) begin
         case ($urandom_range(0, 2))
            0: tol = CSR_W'($urandom_range(0, 255));
            1: tol = CSR_W'($urandom_range(0, 65535));
            default: tol = CSR_W'($urandom);
         endcase
         if ($urandom_range(0, 1) == 0) begin
            inv = CSR_W'($urandom_range(68019, 88019));
         end else begin
            inv = CSR_W'($urandom_range(1, 8388607));
         end
         set_regs(tol, inv);
         repeat (50) send_tick(random_tick());
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else begin
         rsp_stall <= !rsp_stall;
         stall_run <= rsp_stall ? $urandom_range(0, 200) : $urandom_range(0, 40);
      end
   end

   always @(posedge clock) begin
      otwo_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_poses.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("result with nothing expected: %h", rsp_data);
            end
         end else begin
            want = expected_poses.pop_front();
            check_field("pos_x", want.pos_x, rsp_data.pos_x);
            check_field("pos_y", want.pos_y, rsp_data.pos_y);
            check_field("heading_out", want.heading_out, rsp_data.heading_out);
            check_field("vel_x", want.vel_x, rsp_data.vel_x);
            check_field("vel_y", want.vel_y, rsp_data.vel_y);
            check_field("yaw_rate", want.yaw_rate, rsp_data.yaw_rate);
         end
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_position_saturation();
      test_random_mix();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> omni_three_wheel_odometry.f
hw/rtl/otwo_pkg.sv
hw/rtl/omni_three_wheel_odometry.sv
verif/omni_three_wheel_odometry_tb.sv
